// File: rtl/srrip_pkg.sv
// shared types and constants for the srrip replacement directory
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package srrip_pkg;

   localparam int SLOT_BITS = 4;
   localparam int PAGE_BITS = 32;

   typedef logic [1:0]           rrpv_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   localparam rrpv_type RRPV_DISTANT = 2'd3;
   localparam rrpv_type RRPV_LONG    = 2'd2;
   localparam rrpv_type RRPV_NEAR    = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_page;   // latch a new page word
      logic capture;     // register tag matches and the largest rrpv
      logic commit;      // update the directory and load the result word
   } cmd_type;

endpackage

// File: rtl/srrip_ctrl.sv
// controller state machine of the srrip directory: handshakes and datapath commands
// depends on srrip_pkg
`timescale 1ns / 1ps

module srrip_ctrl
   import srrip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.load_page = 1'b0;
      cmd.capture   = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.capture = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait here until the result register can take the new word
            if (out_free) begin
               cmd.commit = 1'b1;
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.load_page = req_tvalid && req_tready;

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// File: rtl/srrip_datapath.sv
// datapath of the srrip directory: tags, valid marks, rrpvs, compare and victim pick
// depends on srrip_pkg; driven by srrip_ctrl commands
`timescale 1ns / 1ps

module srrip_datapath
   import srrip_pkg::*;
#(
   parameter int WAYS     = 16,
   parameter int TAG_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [PAGE_BITS-1:0] req_page,
   output logic                 rsp_hit,
   output slot_type             rsp_slot
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [TAG_BITS-1:0]  tag_ff [WAYS];
   logic [TAG_BITS-1:0]  tag_in [WAYS];
   logic [WAYS-1:0]      valid_ff, valid_in;
   rrpv_type             rrpv_ff [WAYS];
   rrpv_type             rrpv_in [WAYS];
   logic [WAYS-1:0]      match_ff, match_in;
   rrpv_type             top_ff, top_in;
   logic                 hit_ff, hit_in;
   slot_type             slot_ff, slot_in;

   logic [TAG_BITS-1:0]  page_tag;
   logic [WAYS-1:0]      distant;
   logic [WAYS-1:0]      pick;
   logic [WAYS-1:0]      pick_oh;
   logic                 hit_now;
   logic                 any3, any2, any1;
   rrpv_type             lift;

   assign page_tag = TAG_BITS'(page_ff);
   assign rsp_hit  = hit_ff;
   assign rsp_slot = slot_ff;

   // lookup step: parallel compare and largest rrpv
   always_comb begin
      page_in = cmd.load_page ? req_page : page_ff;
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         match_in[w] = cmd.capture ? (valid_ff[w] && (tag_ff[w] == page_tag)) : match_ff[w];
         any3 = any3 || (rrpv_ff[w] == 2'd3);
         any2 = any2 || (rrpv_ff[w] == 2'd2);
         any1 = any1 || (rrpv_ff[w] == 2'd1);
      end
      if (!cmd.capture) begin
         top_in = top_ff;
      end else if (any3) begin
         top_in = 2'd3;
      end else if (any2) begin
         top_in = 2'd2;
      end else if (any1) begin
         top_in = 2'd1;
      end else begin
         top_in = 2'd0;
      end
   end

   // update step: lowest set bit of the hit vector or of the oldest ways
   always_comb begin
      hit_now = |match_ff;
      lift    = rrpv_type'(RRPV_DISTANT - top_ff);
      for (int w = 0; w < WAYS; w++) begin
         distant[w] = (rrpv_ff[w] == top_ff);
      end
      pick    = hit_now ? match_ff : distant;
      pick_oh = pick & (~pick + {{(WAYS-1){1'b0}}, 1'b1});

      slot_in = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (pick_oh[w]) begin
            slot_in = slot_in | slot_type'(w);
         end
      end
      hit_in = hit_now;
      if (!cmd.commit) begin
         slot_in = slot_ff;
         hit_in  = hit_ff;
      end

      for (int w = 0; w < WAYS; w++) begin
         rrpv_in[w]  = rrpv_ff[w];
         valid_in[w] = valid_ff[w];
         tag_in[w]   = tag_ff[w];
         if (cmd.commit) begin
            if (hit_now) begin
               if (pick_oh[w]) begin
                  rrpv_in[w] = RRPV_NEAR;
               end
            end else if (pick_oh[w]) begin
               rrpv_in[w]  = RRPV_LONG;
               valid_in[w] = 1'b1;
               tag_in[w]   = page_tag;
            end else begin
               rrpv_in[w] = rrpv_type'(rrpv_ff[w] + lift);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int w = 0; w < WAYS; w++) begin
            rrpv_ff[w] <= RRPV_DISTANT;
         end
      end else begin
         valid_ff <= valid_in;
         for (int w = 0; w < WAYS; w++) begin
            rrpv_ff[w] <= rrpv_in[w];
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      match_ff <= match_in;
      top_ff   <= top_in;
      hit_ff   <= hit_in;
      slot_ff  <= slot_in;
      for (int w = 0; w < WAYS; w++) begin
         tag_ff[w] <= tag_in[w];
      end
   end

endmodule

// File: rtl/srrip_replacement_policy_top.sv
// top level of the srrip replacement directory: stream ports, controller and datapath
// depends on srrip_pkg, srrip_ctrl and srrip_datapath
`timescale 1ns / 1ps

//  channel   direction   word                         accepted when
//  req_*     in          tdata[31:0] page             req_tvalid && req_tready
//  rsp_*     out         tdata[0] hit, [4:1] slot     rsp_tvalid && rsp_tready
//
//  an accepted word goes through tag compare, then update into the result register
//  back to back words are paced by the compare/update pair
//  a new word is taken in the update cycle, so the next compare sees the fresh directory
//  a stalled result holds the block in the update cycle until the output register frees
//  synchronous reset clears all valid marks and sets every rrpv to distant; no clearing pass

module srrip_replacement_policy_top
   import srrip_pkg::*;
#(
   parameter int WAYS     = 16,
   parameter int TAG_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] page
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata     // [0] hit, [4:1] slot, [7:5] zero
);

   cmd_type  cmd;
   logic     hit;
   slot_type slot;

   // controller owns both handshakes and the result valid flag
   srrip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // directory state and the result payload register
   srrip_datapath #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_page (req_tdata),
      .rsp_hit  (hit),
      .rsp_slot (slot)
   );

   // result word packed from the lowest bit up, padded to a byte
   assign rsp_tdata = {3'b000, slot, hit};

endmodule

// File: rtl/srrip_checker.sv
// port-level checks for the srrip directory top level, attached by bind
// depends on srrip_replacement_policy_top
`timescale 1ns / 1ps

module srrip_checker #(
   parameter int WAYS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // the compare cycle after an accept takes no new word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken during tag compare");

   // an accepted word leaves a result pending once it has passed the compare and update states
   a_result_due: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##3 rsp_tvalid)
      else $error("no result after accepted word");

   // reported slot names an existing way
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (WAYS > 15) || (int'(rsp_tdata[4:1]) < WAYS))
      else $error("slot beyond way count");

endmodule

bind srrip_replacement_policy_top srrip_checker #(.WAYS(WAYS)) u_srrip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb_srrip_replacement_policy_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the srrip replacement directory top level
// depends on srrip_pkg and srrip_replacement_policy_top; page words are checked
// against a directory model kept inside this file

module tb_srrip_replacement_policy_top;
   import srrip_pkg::*;

   localparam int NUM_WAYS   = 16;
   localparam int RUN_LIMIT  = 200000;   // cycles, far above the slowest legal run
   localparam int MAX_SHOWN  = 10;
   localparam int PHASES     = 9;
   localparam int PHASE_LEN  = 150;
   localparam int TAIL_WAIT  = 10;

   // fields of one result word
   typedef struct packed {
      logic     hit;
      slot_type slot;
   } lookup_word_type;

   // one page word waiting to be sent; drain_first holds it back until all
   // earlier results are in
   typedef struct packed {
      logic                 drain_first;
      logic [PAGE_BITS-1:0] page;
   } page_word_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // [31:0] page
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [0] hit, [4:1] slot, [7:5] zero

   page_word_type        pending_pages[$];
   lookup_word_type      expected_lookups[$];

   // directory model: tag, valid mark and re-reference prediction per way
   logic [PAGE_BITS-1:0] dir_tag   [NUM_WAYS];
   logic                 dir_valid [NUM_WAYS];
   rrpv_type             dir_rrpv  [NUM_WAYS];

   int   mismatches  = 0;
   int   cycle_count = 0;
   int   send_idle   = 0;
   int   recv_stall  = 0;
   logic send_burst  = 1'b0;
   logic recv_burst  = 1'b0;
   logic hold_active = 1'b0;
   int   hold_left   = 0;

   srrip_replacement_policy_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // one directory access: hit refreshes the way to near, miss ages the set
   // until some way is distant and fills the lowest distant way at long
   function automatic lookup_word_type access_directory(input logic [PAGE_BITS-1:0] page);
      lookup_word_type res;
      rrpv_type        top;
      rrpv_type        lift;
      int              victim;
      res    = '0;
      top    = RRPV_NEAR;
      victim = 0;
      // parallel compare, lowest way wins; presence comes from the valid mark only
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (dir_valid[w] && dir_tag[w] == page) begin
            dir_rrpv[w] = RRPV_NEAR;
            res.hit     = 1'b1;
            res.slot    = slot_type'(w);
            return res;
         end
      end
      // aging: shift every value by the distance of the largest from distant
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (dir_rrpv[w] > top) begin
            top = dir_rrpv[w];
         end
      end
      lift = RRPV_DISTANT - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         dir_rrpv[w] = dir_rrpv[w] + lift;
      end
      // priority pick of the first distant way
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (dir_rrpv[w] == RRPV_DISTANT) begin
            victim = w;
         end
      end
      dir_tag[victim]   = page;
      dir_valid[victim] = 1'b1;
      dir_rrpv[victim]  = RRPV_LONG;
      res.hit           = 1'b0;
      res.slot          = slot_type'(victim);
      return res;
   endfunction

   // run limit; a stuck block ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // long receiver hold-offs so the pipeline fills and req_tready drops
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_left   <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) begin
            hold_active <= 1'b0;
         end
      end else if (cycle_count == 1500 || cycle_count == 4000) begin
         hold_active <= 1'b1;
         hold_left   <= 300;
      end
   end

   // sender: takes page words from the pending queue, predicts each one at accept
   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_idle  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_lookups.push_back(access_directory(req_tdata));
            // occasionally switch between back-to-back words and random gaps
            if ($urandom_range(0, 39) == 0) begin
               send_burst = !send_burst;
            end
            send_idle = send_burst ? 0 : $urandom_range(0, 6);
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               send_idle--;
            end else if (pending_pages.size() != 0 &&
                         (!pending_pages[0].drain_first || expected_lookups.size() == 0)) begin
               req_tdata <= pending_pages[0].page;
               void'(pending_pages.pop_front());
               offer = 1'b1;
            end
            req_tvalid <= offer;
         end
      end
   end

   // receiver: random stalls per word, checks each result against the oldest prediction
   always @(posedge clock) begin
      lookup_word_type got;
      lookup_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit  = rsp_tdata[0];
            got.slot = rsp_tdata[4:1];
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("unexpected result word: hit %0b slot %0d", got.hit, got.slot);
               end
            end else begin
               want = expected_lookups.pop_front();
               if (got.hit !== want.hit || got.slot !== want.slot) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN) begin
                     $display("result mismatch: expected hit %0b slot %0d, got hit %0b slot %0d",
                              want.hit, want.slot, got.hit, got.slot);
                  end
               end
            end
            if ($urandom_range(0, 39) == 0) begin
               recv_burst = !recv_burst;
            end
            recv_stall = recv_burst ? 0 : $urandom_range(0, 6);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !hold_active;
         end
      end
   end

   task automatic queue_page(input logic [PAGE_BITS-1:0] page, input logic drain_first);
      page_word_type item;
      item.page        = page;
      item.drain_first = drain_first;
      pending_pages.push_back(item);
   endtask

   // stimulus and end of run
   initial begin
      logic [PAGE_BITS-1:0] working_set[$];
      logic [PAGE_BITS-1:0] page;
      int                   set_size;

      // directory starts empty, every way distant
      for (int w = 0; w < NUM_WAYS; w++) begin
         dir_tag[w]   = '0;
         dir_valid[w] = 1'b0;
         dir_rrpv[w]  = RRPV_DISTANT;
      end

      // page zero is a real tag: miss into way 0, then hit
      queue_page(32'h0000_0000, 1'b0);
      queue_page(32'h0000_0000, 1'b0);
      // all-ones page next to it
      queue_page(32'hFFFF_FFFF, 1'b0);
      queue_page(32'hFFFF_FFFF, 1'b0);
      // invalid ways fill in way order
      for (int p = 1; p <= 14; p++) begin
         queue_page(PAGE_BITS'(p), 1'b0);
      end
      // full set: a miss forces aging, then refresh and more evictions
      queue_page(32'h8000_0000, 1'b0);
      queue_page(32'h0000_0000, 1'b0);
      queue_page(32'h5555_5555, 1'b0);
      queue_page(32'hAAAA_AAAA, 1'b0);
      queue_page(32'h0000_0001, 1'b0);

      // random part: each phase works on its own set of pages, mostly reused so
      // hits, refreshes and aging all happen; the first word waits for a drain
      for (int phase = 0; phase < PHASES; phase++) begin
         set_size = $urandom_range(12, 28);
         working_set.delete();
         for (int i = 0; i < set_size; i++) begin
            working_set.push_back($urandom());
         end
         if (phase % 3 == 0) begin
            working_set[0] = '0;
            working_set[1] = '1;
         end
         for (int i = 0; i < PHASE_LEN; i++) begin
            if ($urandom_range(0, 99) < 85) begin
               page = working_set[$urandom_range(0, working_set.size() - 1)];
            end else begin
               page = $urandom();
            end
            queue_page(page, i == 0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // checked between edges so the queues and req_tvalid agree
      while (pending_pages.size() != 0 || req_tvalid || expected_lookups.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
